// File: hw/rtl/tfvc_pkg.sv
`default_nettype none

package tfvc_pkg;

    // register map, word index taken from paddr[4:2]
    localparam logic [2:0] REG_OBSTACLE_RANGE      = 3'd0;
    localparam logic [2:0] REG_OBSTACLE_CONE       = 3'd1;
    localparam logic [2:0] REG_TURN_ANGLE_LIMIT    = 3'd2;
    localparam logic [2:0] REG_SLOW_DISTANCE_LIMIT = 3'd3;
    localparam logic [2:0] REG_MAX_TURN_RATE       = 3'd4;
    localparam logic [2:0] REG_MAX_FORWARD_SPEED   = 3'd5;

    localparam logic [14:0] RST_OBSTACLE_RANGE      = 15'd2867;
    localparam logic [13:0] RST_OBSTACLE_CONE       = 14'd1430;
    localparam logic [12:0] RST_TURN_ANGLE_LIMIT    = 13'd2145;
    localparam logic [14:0] RST_SLOW_DISTANCE_LIMIT = 15'd410;
    localparam logic [14:0] RST_MAX_TURN_RATE       = 15'd4096;
    localparam logic [14:0] RST_MAX_FORWARD_SPEED   = 15'd1229;

    // cordic datapath widths
    localparam int unsigned CX_W         = 36;
    localparam int unsigned CZ_W         = 34;
    localparam int unsigned CORDIC_STEPS = 24;
    localparam logic [CZ_W-1:0] PI_Q30   = 34'd3373259426;

    // arctangent of 2^-i in radians, q.30
    function automatic logic [29:0] atan_q30(input logic [4:0] i);
        logic [29:0] v;
        case (i)
            5'd0:    v = 30'd843314857;
            5'd1:    v = 30'd497837829;
            5'd2:    v = 30'd263043837;
            5'd3:    v = 30'd133525159;
            5'd4:    v = 30'd67021687;
            5'd5:    v = 30'd33543516;
            5'd6:    v = 30'd16775851;
            5'd7:    v = 30'd8388437;
            5'd8:    v = 30'd4194283;
            5'd9:    v = 30'd2097149;
            5'd10:   v = 30'd1048575;
            5'd11:   v = 30'd524287;
            5'd12:   v = 30'd262143;
            5'd13:   v = 30'd131071;
            5'd14:   v = 30'd65535;
            5'd15:   v = 30'd32767;
            5'd16:   v = 30'd16383;
            5'd17:   v = 30'd8191;
            5'd18:   v = 30'd4095;
            5'd19:   v = 30'd2047;
            5'd20:   v = 30'd1023;
            5'd21:   v = 30'd511;
            5'd22:   v = 30'd255;
            5'd23:   v = 30'd127;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/target_follow_velocity_command.sv
`default_nettype none

// channel   handshake                   payload
// -------   -------------------------   ----------------------------------------------
// in        in_valid / in_ready         mode, target_x, target_y,
//                                       obstacle_distance_in, obstacle_angle_in
// out       out_valid / out_ready       target_distance, target_bearing, turn_rate,
//                                       forward_speed, obstacle_stop
// config    psel/penable/pwrite/pready  paddr, pwdata, prdata
//
// an obstacle report only updates the stored obstacle and gives no result
// a target request runs 24 cordic rotations (the root is found alongside in the first
// sixteen), two one-bit-per-cycle divisions of NW steps (NW = max(31, 15+FRAC_BITS))
// and a 13-step shift-add multiply; a saturated turn, a zero angle limit, a target at
// or past the slow distance or an obstacle stop skips the steps it does not need
// reset sets control state, config registers, stored obstacle (five metres, dead ahead)
// the finished result sits in the output register, so a new request is taken while it waits;
// only a second finished result waits on out_ready
module target_follow_velocity_command #(
    parameter int unsigned FRAC_BITS = 12
) (
    input  wire logic               clk,
    input  wire logic               rst_n,

    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               mode,
    input  wire logic signed [15:0] target_x,
    input  wire logic signed [15:0] target_y,
    input  wire logic [14:0]        obstacle_distance_in,
    input  wire logic signed [14:0] obstacle_angle_in,

    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [15:0]             target_distance,
    output logic signed [14:0]      target_bearing,
    output logic signed [15:0]      turn_rate,
    output logic [14:0]             forward_speed,
    output logic                    obstacle_stop,

    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [4:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    // widths that follow from the fraction size
    localparam int unsigned NW    = (15 + FRAC_BITS > 31) ? 15 + FRAC_BITS : 31;
    localparam int unsigned CNTW  = $clog2(NW + 1);
    localparam int unsigned BW    = FRAC_BITS + 3;
    localparam int unsigned CMPW  = (BW > 14) ? BW + 1 : 15;
    localparam int unsigned SW    = FRAC_BITS + 16;
    localparam int unsigned PW    = SW + 13;
    localparam int unsigned CX_W  = tfvc_pkg::CX_W;
    localparam int unsigned CZ_W  = tfvc_pkg::CZ_W;
    localparam logic [CZ_W-1:0] RND_HALF = CZ_W'(1) << (29 - FRAC_BITS);
    localparam int unsigned NO_OBS_RAW = 5 << FRAC_BITS;
    localparam logic [14:0] NO_OBSTACLE = (NO_OBS_RAW > 32767) ? 15'd32767 : 15'(NO_OBS_RAW);

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_SETUP = 10'b0000000010,
        ST_ROT   = 10'b0000000100,
        ST_ROUND = 10'b0000001000,
        ST_TURN  = 10'b0000010000,
        ST_DIVQ  = 10'b0000100000,
        ST_MUL   = 10'b0001000000,
        ST_SPEED = 10'b0010000000,
        ST_DIVS  = 10'b0100000000,
        ST_FIN   = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [14:0] range_reg;
    logic [13:0] cone_reg;
    logic [12:0] angle_lim_reg;
    logic [14:0] dist_lim_reg;
    logic [14:0] max_turn_reg;
    logic [14:0] max_speed_reg;

    // stored obstacle
    logic [14:0]        obs_dist_reg;
    logic signed [15:0] obs_bear_reg;

    // working registers
    logic signed [15:0]     x_reg, y_reg;
    logic [31:0]            n_reg;
    logic [17:0]            sq_rem_reg;
    logic [15:0]            root_reg;
    logic signed [CX_W-1:0] cx_reg, cy_reg;
    logic signed [CZ_W-1:0] cz_reg;
    logic                   zero_reg;
    logic [CNTW-1:0]        cnt_reg;
    logic signed [BW-1:0]   b_reg;
    logic                   stop_reg;
    logic                   tsat_reg;
    logic signed [SW-1:0]   diff_reg;
    logic [NW-1:0]          div_num_reg;
    logic [15:0]            div_rem_reg;
    logic [14:0]            div_den_reg;
    logic signed [PW-1:0]   mcand_reg, acc_reg;
    logic [12:0]            mplier_reg;
    logic signed [15:0]     turn_reg;
    logic [14:0]            speed_reg;

    logic out_valid_reg;
    logic in_acc, out_free, cfg_wr;

    always_comb
    begin
        in_ready = (state_reg == ST_IDLE);
        in_acc   = in_valid & in_ready;
        out_free = ~out_valid_reg | out_ready;
        cfg_wr   = psel & penable & pwrite;
        pready   = 1'b1;
        out_valid = out_valid_reg;
    end

    // register read
    always_comb
    begin
        case (paddr[4:2])
            tfvc_pkg::REG_OBSTACLE_RANGE:      prdata = {17'd0, range_reg};
            tfvc_pkg::REG_OBSTACLE_CONE:       prdata = {18'd0, cone_reg};
            tfvc_pkg::REG_TURN_ANGLE_LIMIT:    prdata = {19'd0, angle_lim_reg};
            tfvc_pkg::REG_SLOW_DISTANCE_LIMIT: prdata = {17'd0, dist_lim_reg};
            tfvc_pkg::REG_MAX_TURN_RATE:       prdata = {17'd0, max_turn_reg};
            tfvc_pkg::REG_MAX_FORWARD_SPEED:   prdata = {17'd0, max_speed_reg};
            default:                           prdata = 32'd0;
        endcase
    end

    // squares and cordic start vector
    logic [31:0]            xsq, ysq;
    logic signed [16:0]     xe, ye;
    logic signed [CX_W-1:0] cx_init, cy_init;
    logic signed [CZ_W-1:0] cz_init;

    always_comb
    begin
        xsq = 32'($signed(x_reg) * $signed(x_reg));
        ysq = 32'($signed(y_reg) * $signed(y_reg));
        xe  = 17'(x_reg);
        ye  = 17'(y_reg);
        cz_init = '0;
        if (x_reg < 0)
        begin
            // turn the vector by a half revolution first
            xe = -xe;
            ye = -ye;
            cz_init = (y_reg >= 0) ? $signed(tfvc_pkg::PI_Q30) : -$signed(tfvc_pkg::PI_Q30);
        end
        cx_init = CX_W'(xe) <<< 16;
        cy_init = CX_W'(ye) <<< 16;
    end

    // one cordic rotation and one root digit
    logic signed [CX_W-1:0] xs, ys;
    logic signed [CZ_W-1:0] atan_step;
    logic [17:0]            sq_sh, sq_trial;

    always_comb
    begin
        xs = cx_reg >>> cnt_reg[4:0];
        ys = cy_reg >>> cnt_reg[4:0];
        atan_step = $signed(CZ_W'(tfvc_pkg::atan_q30(cnt_reg[4:0])));
        sq_sh    = {sq_rem_reg[15:0], n_reg[31:30]};
        sq_trial = {root_reg, 2'b01};
    end

    // bearing rounding, half away from zero
    logic [CZ_W-1:0]      zmag, zrnd;
    logic signed [BW-1:0] b_mag, b_new;

    always_comb
    begin
        zmag  = (cz_reg < 0) ? CZ_W'(-cz_reg) : CZ_W'(cz_reg);
        zrnd  = (zmag + RND_HALF) >> (30 - FRAC_BITS);
        b_mag = BW'(zrnd);
        if (zero_reg)
            b_new = '0;
        else if (cz_reg < 0)
            b_new = -b_mag;
        else
            b_new = b_mag;
    end

    // turn shaping terms
    logic signed [CMPW-1:0] b_cmp, a_cmp;
    logic [12:0]            b_abs;
    logic [25:0]            bsq, asq;
    logic signed [26:0]     dsq;
    logic                   b_neg;

    always_comb
    begin
        b_cmp = CMPW'(b_reg);
        a_cmp = $signed(CMPW'(angle_lim_reg));
        b_neg = b_reg[BW-1];
        b_abs = b_neg ? 13'(-b_reg) : 13'(b_reg);
        bsq   = 26'(b_abs * b_abs);
        asq   = 26'(angle_lim_reg * angle_lim_reg);
        dsq   = $signed({1'b0, bsq}) - $signed({1'b0, asq});
    end

    // shared restoring divider, one quotient bit a cycle
    logic [15:0]   div_sh;
    logic          div_bit;
    logic [15:0]   div_rem_next;
    logic [NW-1:0] div_num_next;

    always_comb
    begin
        div_sh  = {div_rem_reg[14:0], div_num_reg[NW-1]};
        div_bit = (div_sh >= {1'b0, div_den_reg});
        div_rem_next = div_bit ? (div_sh - {1'b0, div_den_reg}) : div_sh;
        div_num_next = {div_num_reg[NW-2:0], div_bit};
    end

    // turn clamp
    logic signed [PW-1:0] prod, tt, m_ext;
    logic signed [15:0]   t_clamp;
    logic signed [SW-1:0] s_new;

    always_comb
    begin
        s_new = diff_reg + $signed({1'b0, div_num_next[SW-2:0]});
        prod  = b_neg ? -acc_reg : acc_reg;
        tt    = prod >>> FRAC_BITS;
        m_ext = $signed(PW'(max_turn_reg));
        if (tt > m_ext)
            t_clamp = $signed({1'b0, max_turn_reg});
        else if (tt < -m_ext)
            t_clamp = -$signed({1'b0, max_turn_reg});
        else
            t_clamp = 16'(tt);
    end

    logic turn_sat_hi, turn_sat_lo, turn_zero;
    logic speed_full;

    always_comb
    begin
        turn_sat_hi = (b_cmp > a_cmp);
        turn_sat_lo = (b_cmp < -a_cmp);
        turn_zero   = (angle_lim_reg == 13'd0);
        speed_full  = (root_reg >= {1'b0, dist_lim_reg});
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && mode)
                    state_next = ST_SETUP;
            end
            ST_SETUP: state_next = ST_ROT;
            ST_ROT:
            begin
                if (cnt_reg == CNTW'(tfvc_pkg::CORDIC_STEPS - 1))
                    state_next = ST_ROUND;
            end
            ST_ROUND: state_next = ST_TURN;
            ST_TURN:
            begin
                if (stop_reg)
                    state_next = ST_FIN;
                else if (turn_sat_hi || turn_sat_lo || turn_zero)
                    state_next = ST_SPEED;
                else
                    state_next = ST_DIVQ;
            end
            ST_DIVQ:
            begin
                if (cnt_reg == CNTW'(NW - 1))
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                if (cnt_reg == CNTW'(12))
                    state_next = ST_SPEED;
            end
            ST_SPEED: state_next = speed_full ? ST_FIN : ST_DIVS;
            ST_DIVS:
            begin
                if (cnt_reg == CNTW'(NW - 1))
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control and configuration state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            range_reg     <= tfvc_pkg::RST_OBSTACLE_RANGE;
            cone_reg      <= tfvc_pkg::RST_OBSTACLE_CONE;
            angle_lim_reg <= tfvc_pkg::RST_TURN_ANGLE_LIMIT;
            dist_lim_reg  <= tfvc_pkg::RST_SLOW_DISTANCE_LIMIT;
            max_turn_reg  <= tfvc_pkg::RST_MAX_TURN_RATE;
            max_speed_reg <= tfvc_pkg::RST_MAX_FORWARD_SPEED;
            obs_dist_reg  <= NO_OBSTACLE;
            obs_bear_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (state_reg == ST_FIN && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            if (cfg_wr)
            begin
                case (paddr[4:2])
                    tfvc_pkg::REG_OBSTACLE_RANGE:      range_reg     <= pwdata[14:0];
                    tfvc_pkg::REG_OBSTACLE_CONE:       cone_reg      <= pwdata[13:0];
                    tfvc_pkg::REG_TURN_ANGLE_LIMIT:    angle_lim_reg <= pwdata[12:0];
                    tfvc_pkg::REG_SLOW_DISTANCE_LIMIT: dist_lim_reg  <= pwdata[14:0];
                    tfvc_pkg::REG_MAX_TURN_RATE:       max_turn_reg  <= pwdata[14:0];
                    tfvc_pkg::REG_MAX_FORWARD_SPEED:   max_speed_reg <= pwdata[14:0];
                    default: ;
                endcase
            end

            // obstacle report, a zero range means nothing seen
            if (in_acc && !mode)
            begin
                obs_dist_reg <= (obstacle_distance_in == 15'd0) ? NO_OBSTACLE
                                                                : obstacle_distance_in;
                obs_bear_reg <= 16'(obstacle_angle_in);
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && mode)
                begin
                    x_reg <= target_x;
                    y_reg <= target_y;
                end
            end
            ST_SETUP:
            begin
                n_reg      <= xsq + ysq;
                sq_rem_reg <= '0;
                root_reg   <= '0;
                cx_reg     <= cx_init;
                cy_reg     <= cy_init;
                cz_reg     <= cz_init;
                zero_reg   <= (x_reg == 16'sd0) && (y_reg == 16'sd0);
                cnt_reg    <= '0;
            end
            ST_ROT:
            begin
                if (cy_reg > 0)
                begin
                    cx_reg <= cx_reg + ys;
                    cy_reg <= cy_reg - xs;
                    cz_reg <= cz_reg + atan_step;
                end
                else
                begin
                    cx_reg <= cx_reg - ys;
                    cy_reg <= cy_reg + xs;
                    cz_reg <= cz_reg - atan_step;
                end
                // root digits ride on the first sixteen rotations
                if (cnt_reg < CNTW'(16))
                begin
                    n_reg <= {n_reg[29:0], 2'b00};
                    if (sq_sh >= sq_trial)
                    begin
                        sq_rem_reg <= sq_sh - sq_trial;
                        root_reg   <= {root_reg[14:0], 1'b1};
                    end
                    else
                    begin
                        sq_rem_reg <= sq_sh;
                        root_reg   <= {root_reg[14:0], 1'b0};
                    end
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
            ST_ROUND:
            begin
                b_reg    <= b_new;
                stop_reg <= (obs_dist_reg < range_reg)
                          && (obs_bear_reg < $signed({2'b00, cone_reg}))
                          && (obs_bear_reg > -$signed({2'b00, cone_reg}));
            end
            ST_TURN:
            begin
                cnt_reg     <= '0;
                tsat_reg    <= 1'b1;
                diff_reg    <= SW'(dsq >>> FRAC_BITS);
                div_num_reg <= NW'(max_turn_reg) << FRAC_BITS;
                div_rem_reg <= '0;
                div_den_reg <= {2'b00, angle_lim_reg};
                if (stop_reg)
                begin
                    turn_reg  <= '0;
                    speed_reg <= '0;
                end
                else if (turn_sat_hi)
                    turn_reg <= $signed({1'b0, max_turn_reg});
                else if (turn_sat_lo)
                    turn_reg <= -$signed({1'b0, max_turn_reg});
                else if (turn_zero)
                    turn_reg <= '0;
                else
                    tsat_reg <= 1'b0;
            end
            ST_DIVQ:
            begin
                div_rem_reg <= div_rem_next;
                div_num_reg <= div_num_next;
                if (cnt_reg == CNTW'(NW - 1))
                begin
                    mcand_reg  <= PW'(s_new);
                    mplier_reg <= b_abs;
                    acc_reg    <= '0;
                    cnt_reg    <= '0;
                end
                else
                    cnt_reg <= cnt_reg + 1'b1;
            end
            ST_MUL:
            begin
                if (mplier_reg[0])
                    acc_reg <= acc_reg + mcand_reg;
                mcand_reg  <= mcand_reg <<< 1;
                mplier_reg <= mplier_reg >> 1;
                cnt_reg    <= cnt_reg + 1'b1;
            end
            ST_SPEED:
            begin
                if (!tsat_reg)
                    turn_reg <= t_clamp;
                if (speed_full)
                    speed_reg <= max_speed_reg;
                div_num_reg <= NW'(max_speed_reg * root_reg);
                div_rem_reg <= '0;
                div_den_reg <= dist_lim_reg;
                cnt_reg     <= '0;
            end
            ST_DIVS:
            begin
                div_rem_reg <= div_rem_next;
                div_num_reg <= div_num_next;
                cnt_reg     <= cnt_reg + 1'b1;
                if (cnt_reg == CNTW'(NW - 1))
                    speed_reg <= div_num_next[14:0];
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    target_distance <= root_reg;
                    target_bearing  <= 15'(b_reg);
                    turn_rate       <= turn_reg;
                    forward_speed   <= speed_reg;
                    obstacle_stop   <= stop_reg;
                end
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire
